// ===== design/zwm_pkg.sv =====
// Package for the window drag and stacking manager.
// Holds the window count, coordinate and cell types, register indexes and reset positions.
// Used by zwm_cell and window_drag_zorder_manager.
package zwm_pkg;

	localparam int NUM_WINDOWS = 2;
	localparam int IDX_W = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;

	localparam int COORD_W = 13;
	localparam int MOUSE_W = 12;
	localparam int WIDTH_W = 12;
	localparam int HEIGHT_W = 6;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TITLEBAR_HEIGHT = 1'b1;

	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 12'd360;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 6'd24;

	localparam int LEFT_BASE = 120;
	localparam int LEFT_STEP = 300;
	localparam int TOP_BASE = 100;
	localparam int TOP_STEP = 160;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic [IDX_W-1:0] id;
		coord_t left;
		coord_t top;
	} cell_data_t;

	typedef struct packed {
		logic [MOUSE_W-1:0] mx;
		logic [MOUSE_W-1:0] my;
		logic [WIDTH_W-1:0] width;
		logic [HEIGHT_W-1:0] height;
	} probe_t;

	typedef struct packed {
		logic hit_en;
		logic grab_en;
		logic move_en;
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HIT,
		PH_MOVE
	} phase_t;

	function automatic cell_data_t init_cell(input int pos);
		cell_data_t d;
		d.id = IDX_W'(pos);
		d.left = COORD_W'(LEFT_BASE + LEFT_STEP * pos);
		d.top = COORD_W'(TOP_BASE + TOP_STEP * pos);
		return d;
	endfunction

endpackage

// ===== design/zwm_cell.sv =====
// One stacking slot: holds a window id and its position, tests the pointer against its title bar.
// Passes the hit flag toward the back and the grabbed window toward the front.
// Depends on zwm_pkg.
module zwm_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  zwm_pkg::cell_data_t init,
	input  zwm_pkg::probe_t    probe,
	input  zwm_pkg::cell_ctrl_t ctrl,
	input  zwm_pkg::coord_t    move_left,
	input  zwm_pkg::coord_t    move_top,
	input  logic               hit_above_in,
	output logic               hit_above_out,
	input  zwm_pkg::cell_data_t sel_in,
	output zwm_pkg::cell_data_t sel_out,
	input  zwm_pkg::cell_data_t nbr,
	output zwm_pkg::cell_data_t data
);
	import zwm_pkg::*;

	cell_data_t data_q;
	logic hit_q;
	logic hit;
	logic first;
	logic shift;
	logic signed [COORD_W:0] px, py, l14, t14, r14, b14;

	always_comb begin
		px = {2'b00, probe.mx};
		py = {2'b00, probe.my};
		l14 = {data_q.left[COORD_W-1], data_q.left};
		t14 = {data_q.top[COORD_W-1], data_q.top};
		r14 = l14 + signed'({2'b00, probe.width});
		b14 = t14 + signed'({{(COORD_W+1-HEIGHT_W){1'b0}}, probe.height});
		hit = (px >= l14) && (px < r14) && (py >= t14) && (py < b14);
	end

	assign first = hit_q & ~hit_above_in;
	assign shift = ctrl.grab_en & ~hit_above_in;
	assign hit_above_out = hit_above_in | hit_q;
	assign sel_out = first ? data_q : sel_in;
	assign data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= init;
			hit_q <= 1'b0;
		end else begin
			if (ctrl.hit_en) begin
				hit_q <= hit;
			end
			if (shift) begin
				data_q <= nbr;
			end else if (ctrl.move_en) begin
				data_q.left <= move_left;
				data_q.top <= move_top;
			end
		end
	end

endmodule

// ===== design/window_drag_zorder_manager.sv =====
// Top level of the window drag and stacking manager.
// Builds the row of zwm_cell slots, the sample and drag registers and the result register.
// Depends on zwm_pkg and zwm_cell.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one mouse sample per item: mouse_x,
//   mouse_y and left_button. Output channel (out_valid / out_stall) returns one result
//   item per sample: redraw, drag_active, drag_window, window_left, window_top and
//   top_window.
//   Windows sit in a row of cells ordered back to front; the last cell is frontmost.
//   A sample is registered at acceptance, every cell tests its title bar in the next
//   cycle and registers its hit flag, and then, once the output register is free,
//   the grabbed window is handed cell to cell to the front, the dragged window follows
//   the pointer and the result is registered.
//   A new sample is accepted only as the previous one finishes, since the registered
//   hit flags of the cells lie between the test cycle and the update cycle.
//   When the receiver stalls, the result holds in the output register and the block
//   keeps the finished sample until the register frees; the next sample waits.
//   Reset puts the windows at their initial positions with window 1 frontmost, clears
//   the drag state and the previous sample, and loads width 360 and title bar 24.
//   Configuration writes through cfg_we / cfg_index / cfg_data take effect at once.
module window_drag_zorder_manager (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [zwm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [zwm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [zwm_pkg::MOUSE_W-1:0]         mouse_x,
	input  logic [zwm_pkg::MOUSE_W-1:0]         mouse_y,
	input  logic                                left_button,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                redraw,
	output logic                                drag_active,
	output logic                                drag_window,
	output logic signed [zwm_pkg::COORD_W-1:0]  window_left,
	output logic signed [zwm_pkg::COORD_W-1:0]  window_top,
	output logic                                top_window
);
	import zwm_pkg::*;

	phase_t state_q, state_next;

	logic [WIDTH_W-1:0] width_q;
	logic [HEIGHT_W-1:0] height_q;

	logic [MOUSE_W-1:0] mx_s1, my_s1;
	logic btn_s1;

	logic prev_btn_q;
	logic [MOUSE_W-1:0] prev_x_q, prev_y_q;
	logic drag_q;
	logic [WIDTH_W-1:0] offx_q;
	logic [HEIGHT_W-1:0] offy_q;

	logic out_valid_q;
	logic redraw_q, active_q, dwin_q, topw_q;
	coord_t left_q, top_q;

	logic accept, can_write, fire, hit_en;
	logic press, grab, drag_next, active, moved;
	logic [COORD_W-1:0] diff_left, diff_top;
	coord_t new_left, new_top;
	logic [IDX_W-1:0] front_id;

	probe_t probe;
	cell_ctrl_t ctrl [NUM_WINDOWS];
	cell_data_t data_w [NUM_WINDOWS];
	cell_data_t sel_w [NUM_WINDOWS];
	cell_data_t nbr_w [NUM_WINDOWS];
	logic hit_above_w [NUM_WINDOWS+1];
	cell_data_t sel;
	logic any_hit;

	assign can_write = ~out_valid_q | ~out_stall;

	always_comb begin
		in_stall = 1'b1;
		fire = 1'b0;
		hit_en = 1'b0;
		unique case (state_q)
			PH_IDLE: begin
				in_stall = 1'b0;
			end
			PH_HIT: begin
				hit_en = 1'b1;
			end
			PH_MOVE: begin
				fire = can_write;
				in_stall = ~can_write;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	assign accept = in_valid & ~in_stall;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			PH_IDLE: begin
				if (accept) state_next = PH_HIT;
			end
			PH_HIT: begin
				state_next = PH_MOVE;
			end
			PH_MOVE: begin
				if (fire) state_next = accept ? PH_HIT : PH_IDLE;
			end
			default: begin
				state_next = PH_IDLE;
			end
		endcase
	end

	assign probe = '{mx: mx_s1, my: my_s1, width: width_q, height: height_q};

	assign press = btn_s1 & ~prev_btn_q;
	assign grab = press & any_hit;
	assign drag_next = grab | (drag_q & btn_s1);
	assign active = drag_next & btn_s1;
	assign moved = (mx_s1 != prev_x_q) | (my_s1 != prev_y_q);

	assign diff_left = {1'b0, mx_s1} - {1'b0, offx_q};
	assign diff_top = {1'b0, my_s1} - {{(COORD_W-HEIGHT_W){1'b0}}, offy_q};
	assign new_left = grab ? sel.left : coord_t'(diff_left);
	assign new_top = grab ? sel.top : coord_t'(diff_top);
	assign front_id = grab ? sel.id : data_w[NUM_WINDOWS-1].id;

	assign hit_above_w[NUM_WINDOWS] = 1'b0;
	assign any_hit = hit_above_w[0];
	assign sel = sel_w[NUM_WINDOWS-1];

	for (genvar i = 0; i < NUM_WINDOWS; i++) begin : g_cell
		assign ctrl[i].hit_en = hit_en;
		assign ctrl[i].grab_en = fire & grab;
		assign ctrl[i].move_en = (i == NUM_WINDOWS - 1) ? (fire & active & ~grab) : 1'b0;
		assign nbr_w[i] = (i == NUM_WINDOWS - 1) ? sel : data_w[(i + 1) % NUM_WINDOWS];

		zwm_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.init         (init_cell(i)),
			.probe        (probe),
			.ctrl         (ctrl[i]),
			.move_left    (new_left),
			.move_top     (new_top),
			.hit_above_in (hit_above_w[i+1]),
			.hit_above_out(hit_above_w[i]),
			.sel_in       ((i == 0) ? cell_data_t'('0) : sel_w[(i + NUM_WINDOWS - 1) % NUM_WINDOWS]),
			.sel_out      (sel_w[i]),
			.nbr          (nbr_w[i]),
			.data         (data_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_IDLE;
			width_q <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			prev_btn_q <= 1'b0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			drag_q <= 1'b0;
			offx_q <= '0;
			offy_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_WINDOW_WIDTH: width_q <= cfg_data;
					CFG_TITLEBAR_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
					default: ;
				endcase
			end
			if (fire) begin
				prev_btn_q <= btn_s1;
				prev_x_q <= mx_s1;
				prev_y_q <= my_s1;
				drag_q <= drag_next;
				if (grab) begin
					offx_q <= mx_s1 - sel.left[WIDTH_W-1:0];
					offy_q <= my_s1[HEIGHT_W-1:0] - sel.top[HEIGHT_W-1:0];
				end
				out_valid_q <= 1'b1;
			end else if (~out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mx_s1 <= mouse_x;
			my_s1 <= mouse_y;
			btn_s1 <= left_button;
		end
		if (fire) begin
			redraw_q <= moved | grab | active;
			active_q <= active;
			dwin_q <= active ? front_id[0] : 1'b0;
			left_q <= active ? new_left : '0;
			top_q <= active ? new_top : '0;
			topw_q <= front_id[0];
		end
	end

	assign out_valid = out_valid_q;
	assign redraw = redraw_q;
	assign drag_active = active_q;
	assign drag_window = dwin_q;
	assign window_left = left_q;
	assign window_top = top_q;
	assign top_window = topw_q;

endmodule

// ===== design/zwm_checker.sv =====
// Port-level checker for window_drag_zorder_manager, attached by bind.
// Watches only the top-level ports; depends on zwm_pkg for widths.
module zwm_assertions (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                cfg_we,
	input logic [zwm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input logic [zwm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic [zwm_pkg::MOUSE_W-1:0]         mouse_x,
	input logic [zwm_pkg::MOUSE_W-1:0]         mouse_y,
	input logic                                left_button,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic                                redraw,
	input logic                                drag_active,
	input logic                                drag_window,
	input logic signed [zwm_pkg::COORD_W-1:0]  window_left,
	input logic signed [zwm_pkg::COORD_W-1:0]  window_top,
	input logic                                top_window
);
	import zwm_pkg::*;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted in back-to-back cycles");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !drag_active |-> drag_window == 1'b0 && window_left == '0 && window_top == '0)
		else $error("drag fields set without an active drag");

	a_drag_redraw: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drag_active |-> redraw)
		else $error("active drag without redraw");

	a_drag_front: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drag_active |-> top_window == drag_window)
		else $error("dragged window is not frontmost");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(window_left) && $stable(window_top)
			&& $stable(drag_active) && $stable(top_window))
		else $error("stalled item changed");

endmodule

bind window_drag_zorder_manager zwm_assertions u_zwm_assertions (.*);
